// File: design/quad_squareness_score_core_defines.svh
// Assertion macros shared by the quad squareness score RTL.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef QUAD_SQUARENESS_SCORE_CORE_DEFINES_SVH
`define QUAD_SQUARENESS_SCORE_CORE_DEFINES_SVH

// Implication checked in the same cycle
`define QSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle
`define QSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/qss_pkg.sv
// Shared types and constants of the quad squareness score core.
// No dependencies.
package qss_pkg;

  // Pipeline control that the top level hands to each term lane
  typedef struct packed {
    logic advance;
  } pipe_ctrl_t;

  // Extra shift bits of the divide-by-three reciprocal
  localparam int unsigned THIRD_EXTRA_BITS = 2;

endpackage

// File: design/quad_squareness_score_core.sv
// Quadrilateral squareness scorer, top level.
// Depends on qss_pkg, qss_term and quad_squareness_score_core_defines.svh.
//
// Usage: one quadrilateral request enters on the s_axis channel, corners
// A, B, C, D packed in tdata (A opposite C). One result leaves on m_axis per
// request, in order: a squareness score in units of 2^-FRAC_BITS and a flag
// for a zero-length side or diagonal (score is then zero).
// Pipeline: FRAC_BITS + 8 register stages: one for corner differences, three
// for products and sums, FRAC_BITS + 1 restoring divider steps, and three for
// the final sum, reciprocal multiply by one third and output register.
// Throughput: one request per cycle while the output is not stalled; the
// three cosine lanes run side by side.
// Reset clears all valid bits; payload registers are not reset.
// Stall: when the output holds a result that is not taken, the whole pipeline
// freezes and s_axis_tready_o drops; nothing is lost or repeated, and
// bubbles in the pipeline are not squeezed out.
`include "quad_squareness_score_core_defines.svh"

module quad_squareness_score_core #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from the lowest bit up
  input  logic [8*COORD_BITS-1:0] s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // score, degenerate from the lowest bit up, zero fill above
  output logic [((FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned OUT_W = ((FRAC_BITS + 2 + 7) / 8) * 8;
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned SW    = FRAC_BITS + 2;
  localparam int unsigned RS    = SW + qss_pkg::THIRD_EXTRA_BITS;
  localparam logic [SW:0] RECIP = (SW+1)'((64'd1 << RS) / 3 + 1);
  localparam int unsigned DEPTH = FRAC_BITS + 8;

  logic stall, adv;
  qss_pkg::pipe_ctrl_t ctrl;

  // Freeze everything while the output holds an untaken result
  assign stall           = m_axis_tvalid_o && !m_axis_tready_i;
  assign adv             = !stall;
  assign ctrl.advance    = adv;
  assign s_axis_tready_o = adv;

  // Valid and degenerate flags travel with the data
  logic [DEPTH-1:0] valid_q;
  logic [DEPTH-1:0] degen_q;
  logic             degen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[DEPTH-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      degen_q <= {degen_q[DEPTH-2:0], degen_d};
    end
  end

  // Stage 1: corner differences
  logic [C-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  assign ax = s_axis_tdata_i[0*C +: C];
  assign ay = s_axis_tdata_i[1*C +: C];
  assign bx = s_axis_tdata_i[2*C +: C];
  assign by = s_axis_tdata_i[3*C +: C];
  assign cx = s_axis_tdata_i[4*C +: C];
  assign cy = s_axis_tdata_i[5*C +: C];
  assign dx = s_axis_tdata_i[6*C +: C];
  assign dy = s_axis_tdata_i[7*C +: C];

  logic signed [C:0] abx_d, aby_d, adx_d, ady_d, cbx_d, cby_d;
  logic signed [C:0] cdx_d, cdy_d, acx_d, acy_d, dbx_d, dby_d;
  always_comb begin
    abx_d = $signed({1'b0, bx}) - $signed({1'b0, ax});
    aby_d = $signed({1'b0, by}) - $signed({1'b0, ay});
    adx_d = $signed({1'b0, dx}) - $signed({1'b0, ax});
    ady_d = $signed({1'b0, dy}) - $signed({1'b0, ay});
    cbx_d = $signed({1'b0, bx}) - $signed({1'b0, cx});
    cby_d = $signed({1'b0, by}) - $signed({1'b0, cy});
    cdx_d = $signed({1'b0, dx}) - $signed({1'b0, cx});
    cdy_d = $signed({1'b0, dy}) - $signed({1'b0, cy});
    acx_d = $signed({1'b0, cx}) - $signed({1'b0, ax});
    acy_d = $signed({1'b0, cy}) - $signed({1'b0, ay});
    dbx_d = $signed({1'b0, bx}) - $signed({1'b0, dx});
    dby_d = $signed({1'b0, by}) - $signed({1'b0, dy});
    // Any coincident pair of corners makes a used vector zero
    degen_d = (ax == bx && ay == by) || (ax == dx && ay == dy) ||
              (cx == bx && cy == by) || (cx == dx && cy == dy) ||
              (ax == cx && ay == cy) || (dx == bx && dy == by);
  end

  logic signed [C:0] abx_q, aby_q, adx_q, ady_q, cbx_q, cby_q;
  logic signed [C:0] cdx_q, cdy_q, acx_q, acy_q, dbx_q, dby_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      abx_q <= abx_d;  aby_q <= aby_d;
      adx_q <= adx_d;  ady_q <= ady_d;
      cbx_q <= cbx_d;  cby_q <= cby_d;
      cdx_q <= cdx_d;  cdy_q <= cdy_d;
      acx_q <= acx_d;  acy_q <= acy_d;
      dbx_q <= dbx_d;  dby_q <= dby_d;
    end
  end

  // Three squared-cosine lanes
  logic [QW-1:0] term_a, term_c, term_g;

  qss_term #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_term_a (
    .clk_i, .ctrl_i(ctrl),
    .ux_i(abx_q), .uy_i(aby_q), .vx_i(adx_q), .vy_i(ady_q), .term_o(term_a)
  );

  qss_term #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_term_c (
    .clk_i, .ctrl_i(ctrl),
    .ux_i(cbx_q), .uy_i(cby_q), .vx_i(cdx_q), .vy_i(cdy_q), .term_o(term_c)
  );

  qss_term #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_term_g (
    .clk_i, .ctrl_i(ctrl),
    .ux_i(acx_q), .uy_i(acy_q), .vx_i(dbx_q), .vy_i(dby_q), .term_o(term_g)
  );

  // Sum of terms, then floor of one third by reciprocal multiply
  logic [SW-1:0]   sum_q;
  logic [2*SW:0]   prod_q;
  logic [QW-1:0]   third;
  logic [FRAC_BITS:0] score_d, score_q;
  logic            degen_out_q;

  assign third   = prod_q[RS +: QW];
  assign score_d = degen_q[DEPTH-2] ? '0 : QW'((QW+1)'(1) << FRAC_BITS) - third;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q       <= SW'(term_a) + SW'(term_c) + SW'(term_g);
      prod_q      <= (2*SW+1)'(sum_q) * (2*SW+1)'(RECIP);
      score_q     <= score_d;
      degen_out_q <= degen_q[DEPTH-2];
    end
  end

  assign m_axis_tvalid_o = valid_q[DEPTH-1];
  assign m_axis_tdata_o  = OUT_W'({degen_out_q, score_q});

  // A degenerate result carries a zero score
  `QSS_ASSERT_IMP(a_degen_zero, m_axis_tvalid_o && degen_out_q, score_q == '0,
                  "degenerate result with nonzero score")
  // The score never exceeds one
  `QSS_ASSERT_IMP(a_score_max, m_axis_tvalid_o,
                  score_q <= QW'((QW+1)'(1) << FRAC_BITS), "score above one")
  // A stall freezes the valid pipeline
  `QSS_ASSERT_NXT(a_stall_freeze, stall, $stable(valid_q),
                  "valid pipeline moved during stall")

endmodule

// File: design/qss_term.sv
// One squared-cosine lane: products, sums, wide products and a
// bit-per-stage restoring divider. Depends on qss_pkg.
module qss_term #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  qss_pkg::pipe_ctrl_t          ctrl_i,
  input  logic signed [COORD_BITS:0]   ux_i,
  input  logic signed [COORD_BITS:0]   uy_i,
  input  logic signed [COORD_BITS:0]   vx_i,
  input  logic signed [COORD_BITS:0]   vy_i,
  output logic        [FRAC_BITS:0]    term_o
);

  localparam int unsigned PW = 2 * COORD_BITS + 2;  // signed product width
  localparam int unsigned LW = 2 * COORD_BITS + 1;  // length squared / magnitude
  localparam int unsigned NW = 2 * LW;              // numerator and denominator
  localparam int unsigned QW = FRAC_BITS + 1;

  // Stage A: elementwise products
  logic signed [PW-1:0] pxx_q, pyy_q, sux_q, suy_q, svx_q, svy_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      pxx_q <= ux_i * vx_i;
      pyy_q <= uy_i * vy_i;
      sux_q <= ux_i * ux_i;
      suy_q <= uy_i * uy_i;
      svx_q <= vx_i * vx_i;
      svy_q <= vy_i * vy_i;
    end
  end

  // Stage B: dot product magnitude and squared lengths
  logic signed [PW-1:0] dot_d, mag_full;
  logic [LW-1:0] mag_q, lu_q, lv_q;
  always_comb begin
    dot_d    = pxx_q + pyy_q;
    mag_full = dot_d[PW-1] ? -dot_d : dot_d;
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      mag_q <= mag_full[LW-1:0];
      lu_q  <= {1'b0, sux_q[LW-2:0]} + {1'b0, suy_q[LW-2:0]};
      lv_q  <= {1'b0, svx_q[LW-2:0]} + {1'b0, svy_q[LW-2:0]};
    end
  end

  // Stage C: numerator and denominator
  logic [NW-1:0] num_q, den_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      num_q <= mag_q * mag_q;
      den_q <= lu_q * lv_q;
    end
  end

  // Divider: the first step compares unshifted, each later one shifts in a zero
  logic [NW-1:0] rem_q [QW];
  logic [NW-1:0] dsr_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NW-1:0] rem_in, dsr_in;
    logic [QW-1:0] quo_in;
    logic [NW:0]   trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_in = num_q;
      assign dsr_in = den_q;
      assign quo_in = '0;
      assign trial  = {1'b0, rem_in};
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dsr_in = dsr_q[k-1];
      assign quo_in = quo_q[k-1];
      assign trial  = {rem_in, 1'b0};
    end
    assign ge = trial >= {1'b0, dsr_in};
    always_ff @(posedge clk_i) begin
      if (ctrl_i.advance) begin
        rem_q[k] <= ge ? NW'(trial - {1'b0, dsr_in}) : trial[NW-1:0];
        dsr_q[k] <= dsr_in;
        quo_q[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign term_o = quo_q[QW-1];

endmodule

// File: tb/sv/quad_squareness_score_core_checker.sv
// Checker for the quad squareness score core: watches both stream channels,
// predicts each result from the accepted corners and compares in order.
// Depends only on the port layout of quad_squareness_score_core.
module quad_squareness_score_core_checker #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  input  logic                    s_axis_tready_i,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from the lowest bit up
  input  logic [8*COORD_BITS-1:0] s_axis_tdata_i,
  input  logic                    m_axis_tvalid_i,
  input  logic                    m_axis_tready_i,
  // score, degenerate from the lowest bit up, zero fill above
  input  logic [23:0]             m_axis_tdata_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        degenerate;
    logic [16:0] score;
  } score_t;

  score_t score_q[$];

  // Squared cosine of two nonzero vectors, quantized to FRAC_BITS
  function automatic longint cos_sq_fixed(longint ux, longint uy, longint vx, longint vy);
    longint      dot;
    bit [127:0]  num;
    bit [127:0]  den;
    dot = ux * vx + uy * vy;
    if (dot < 0) dot = -dot;
    num = 128'(dot) * 128'(dot);
    den = 128'(ux * ux + uy * uy) * 128'(vx * vx + vy * vy);
    if (num >= den) return longint'(1) << FRAC_BITS;
    return longint'((num << FRAC_BITS) / den);
  endfunction

  function automatic score_t predict_score(logic [8*COORD_BITS-1:0] quad);
    longint c[8];
    longint sum;
    score_t r;
    for (int i = 0; i < 8; i++) c[i] = longint'(quad[i*COORD_BITS +: COORD_BITS]);
    // corners: A=(0,1) B=(2,3) C=(4,5) D=(6,7)
    if ((c[2] == c[0] && c[3] == c[1]) || (c[6] == c[0] && c[7] == c[1]) ||
        (c[2] == c[4] && c[3] == c[5]) || (c[6] == c[4] && c[7] == c[5]) ||
        (c[4] == c[0] && c[5] == c[1]) || (c[2] == c[6] && c[3] == c[7])) begin
      r.score = '0;
      r.degenerate = 1'b1;
      return r;
    end
    sum = cos_sq_fixed(c[2]-c[0], c[3]-c[1], c[6]-c[0], c[7]-c[1])
        + cos_sq_fixed(c[2]-c[4], c[3]-c[5], c[6]-c[4], c[7]-c[5])
        + cos_sq_fixed(c[4]-c[0], c[5]-c[1], c[2]-c[6], c[3]-c[7]);
    r.score = 17'((longint'(1) << FRAC_BITS) - sum / 3);
    r.degenerate = 1'b0;
    return r;
  endfunction

  assign pending_o = score_q.size();

  // Queue predictions on input requests, compare on output requests
  always @(posedge clk_i) begin
    score_t exp_r;
    score_t got_r;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) score_q.push_back(predict_score(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_r = score_t'(m_axis_tdata_i[17:0]);
        if (score_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10)
            $display("unexpected result score=%0d degenerate=%0b", got_r.score, got_r.degenerate);
        end else begin
          exp_r = score_q.pop_front();
          if (got_r !== exp_r || m_axis_tdata_i[23:18] !== '0) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: expected score=%0d degenerate=%0b, got score=%0d degenerate=%0b fill=%h",
                       exp_r.score, exp_r.degenerate, got_r.score, got_r.degenerate,
                       m_axis_tdata_i[23:18]);
          end
        end
      end
    end
  end

  initial fail_count_o = 0;

endmodule

// File: tb/sv/quad_squareness_score_core_test.sv
// Top of the quad squareness score testbench: clock, reset, corner stimulus,
// output backpressure and verdict. Depends on quad_squareness_score_core and
// quad_squareness_score_core_checker.
module quad_squareness_score_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB         = 12;
  localparam int unsigned N_RANDOM   = 1330;
  localparam int unsigned DRAIN      = 40;
  localparam int unsigned MAX_CYCLES = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [95:0]   s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [23:0]   m_tdata;
  int            fail_count;
  int            pending;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            cycle_count = 0;

  quad_squareness_score_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata)
  );

  quad_squareness_score_core_checker #(.COORD_BITS(CB)) u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_i(m_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #4 clk_i = ~clk_i;

  // Random backpressure on the result side
  always @(posedge clk_i) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("FAIL quad_squareness_score_core");
      $finish;
    end
  end

  // Offer one quad request, idling at random first, and hold until taken
  task automatic send_quad(input int ax, ay, bx, by, cx, cy, dx, dy);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {dy[CB-1:0], dx[CB-1:0], cy[CB-1:0], cx[CB-1:0],
                 by[CB-1:0], bx[CB-1:0], ay[CB-1:0], ax[CB-1:0]};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Random quad: near-rectangles most often, some free quads, some with merged corners
  task automatic send_random_quad();
    int ax, ay, ux, uy, vx, vy, jit, c[8], kind, i, j;
    kind = $urandom_range(99);
    if (kind < 45) begin
      ux = $urandom_range(1200) - 600;
      uy = $urandom_range(1200) - 600;
      jit = $urandom_range(3) == 0 ? 200 : 8;
      vx = -uy + $urandom_range(2*jit) - jit;
      vy = ux + $urandom_range(2*jit) - jit;
      ax = $urandom_range(4095);
      ay = $urandom_range(4095);
      c[0] = ax; c[1] = ay;
      c[2] = ax + ux; c[3] = ay + uy;
      c[4] = ax + ux + vx + $urandom_range(2*jit) - jit;
      c[5] = ay + uy + vy + $urandom_range(2*jit) - jit;
      c[6] = ax + vx; c[7] = ay + vy;
      for (i = 0; i < 8; i++) c[i] = c[i] < 0 ? 0 : (c[i] > 4095 ? 4095 : c[i]);
    end else begin
      for (i = 0; i < 8; i++) c[i] = $urandom_range(4095);
      if (kind >= 88) begin
        i = $urandom_range(3);
        j = (i + 1 + $urandom_range(2)) % 4;
        c[2*j] = c[2*i];
        c[2*j+1] = c[2*i+1];
      end
    end
    send_quad(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  initial begin
    send_idle_pct = 24;
    recv_stall_pct = 83;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, squares, parallel sides, each coincident pair
    send_quad(0, 0, 0, 0, 0, 0, 0, 0);
    send_quad(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    send_quad(0, 0, 4095, 0, 4095, 4095, 0, 4095);
    send_quad(4095, 4095, 0, 4095, 0, 0, 4095, 0);
    send_quad(10, 10, 20, 10, 20, 20, 10, 20);
    send_quad(2048, 0, 4095, 2048, 2048, 4095, 0, 2048);
    send_quad(0, 0, 4095, 0, 4095, 1, 0, 1);
    send_quad(0, 0, 1, 0, 2, 0, 3, 0);
    send_quad(0, 0, 4095, 4095, 1, 1, 4094, 4094);
    send_quad(0, 0, 4095, 1, 4095, 4095, 1, 4095);
    send_quad(100, 200, 3000, 50, 4000, 3900, 7, 4095);
    send_quad(0, 4095, 4095, 0, 0, 4095, 4095, 4095);
    send_quad(5, 5, 5, 5, 100, 100, 0, 100);
    send_quad(5, 5, 100, 5, 100, 100, 5, 5);
    send_quad(5, 5, 100, 5, 100, 100, 100, 5);
    send_quad(5, 5, 100, 5, 100, 5, 7, 100);
    send_quad(5, 5, 100, 5, 5, 5, 0, 100);
    send_quad(5, 5, 100, 5, 70, 90, 100, 5);
    send_quad(1, 2, 4095, 4094, 3, 4095, 4094, 0);
    send_quad(4095, 0, 0, 4095, 4095, 4095, 0, 0);

    // Random: three idling regimes, the last with none
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) begin
        send_idle_pct = 83;
        recv_stall_pct = 24;
      end else if (k == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      send_random_quad();
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS quad_squareness_score_core");
    end else begin
      $display("FAIL quad_squareness_score_core");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/qss_pkg.sv
design/qss_term.sv
design/quad_squareness_score_core.sv
tb/sv/quad_squareness_score_core_checker.sv
tb/sv/quad_squareness_score_core_test.sv
